FILE: design/service_registry_table_assert.svh
// Assertion macros used by the service registry table module
`ifndef SERVICE_REGISTRY_TABLE_ASSERT_SVH
`define SERVICE_REGISTRY_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/srt_pkg.sv
// Types and codes of the service registry table
package srt_pkg;

	localparam logic [1:0] CMD_OFFER = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_FIND  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_IP     = 2'd1;
	localparam logic [1:0] REG_PORT   = 2'd2;

	typedef struct packed {
		logic [23:0] ttl;
		logic [31:0] minor_version;
		logic [7:0]  major_version;
		logic [15:0] instance_id;
		logic [15:0] service_id;
	} in_data_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  entry_count;
		logic [15:0] found_port;
		logic [31:0] found_ip;
		logic [23:0] found_ttl;
		logic [31:0] found_minor;
		logic [7:0]  found_major;
		logic [15:0] found_instance;
	} out_data_t;

	typedef struct packed {
		logic [15:0] service_id;
		logic [15:0] instance_id;
		logic [7:0]  major_version;
		logic [31:0] minor_version;
		logic [23:0] ttl;
		logic [31:0] ip;
		logic [15:0] port;
	} entry_t;

	typedef struct packed {
		logic match;
		logic free;
	} cmp_res_t;

endpackage

FILE: design/srt_mem.sv
// Entry memory: one write port, one registered read port
module srt_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int W     = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/srt_cmp.sv
// Shared key compare unit used once per scanned entry
module srt_cmp (
	input  logic [1:0]        cmd,
	input  logic [15:0]       service_id,
	input  logic [15:0]       instance_id,
	input  srt_pkg::entry_t   entry,
	input  logic              entry_valid,
	output srt_pkg::cmp_res_t res
);
	import srt_pkg::*;

	logic svc_eq;
	logic inst_eq;

	assign svc_eq  = (entry.service_id == service_id);
	assign inst_eq = (entry.instance_id == instance_id);

	always_comb begin
		res.free  = !entry_valid;
		res.match = entry_valid && svc_eq && ((cmd == CMD_FIND) || inst_eq);
	end
endmodule

FILE: design/service_registry_table.sv
// Service registry table: offer, stop, find and clear over a scanned entry memory
// Flow: a disabled or clear item goes from idle straight to the response state; offer,
// stop and find scan every entry, one per cycle, then commit before the response.
// Items are taken one at a time; s_tready stays low until the response is given. The
// scan runs through the single read port of the entry memory and the one compare unit.
// Reset: arst_n clears valid bits, count, registers and control; entry memory keeps
// its contents and needs no clearing pass.
`include "service_registry_table_assert.svh"

module service_registry_table #(
	parameter int ENTRIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  srt_pkg::in_data_t s_tdata,   // service_id, instance_id, major_version,
	                                     // minor_version, ttl
	input  logic [1:0]        s_tuser,   // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output srt_pkg::out_data_t m_tdata,  // found_instance, found_major, found_minor,
	                                     // found_ttl, found_ip, found_port,
	                                     // entry_count, zero pad
	output logic              m_tuser,   // ok
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import srt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int EW    = $bits(entry_t);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	logic [1:0]         state_q;
	logic               enable_q;
	logic [31:0]        local_ip_q;
	logic [15:0]        local_port_q;
	logic [1:0]         cmd_q;
	in_data_t           item_q;
	logic [IDX_W-1:0]   idx_q;
	logic               issue_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	entry_t             hit_entry_q;
	logic               ok_q;
	entry_t             res_entry_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic               m_tvalid_q;
	out_data_t          m_tdata_q;
	logic               m_tuser_q;

	logic               cfg_we;
	logic               accept;
	logic               out_free;
	logic               mem_we;
	entry_t             mem_wdata;
	logic [EW-1:0]      mem_rdata;
	entry_t             rd_entry;
	cmp_res_t           cmp;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_entry = entry_t'(mem_rdata);

	assign mem_we = (state_q == ST_COMMIT) && (cmd_q == CMD_OFFER) && !hit_q && free_q;

	always_comb begin
		mem_wdata.service_id    = item_q.service_id;
		mem_wdata.instance_id   = item_q.instance_id;
		mem_wdata.major_version = item_q.major_version;
		mem_wdata.minor_version = item_q.minor_version;
		mem_wdata.ttl           = item_q.ttl;
		mem_wdata.ip            = local_ip_q;
		mem_wdata.port          = local_port_q;
	end

	srt_mem #(
		.DEPTH(ENTRIES),
		.AW   (IDX_W),
		.W    (EW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(free_idx_q),
		.wdata(mem_wdata),
		.raddr(idx_q),
		.rdata(mem_rdata)
	);

	srt_cmp u_cmp (
		.cmd        (cmd_q),
		.service_id (item_q.service_id),
		.instance_id(item_q.instance_id),
		.entry      (rd_entry),
		.entry_valid(valid_q[idx_s1]),
		.res        (cmp)
	);

	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_IP:     prdata = local_ip_q;
			REG_PORT:   prdata = {16'd0, local_port_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			local_ip_q   <= 32'd0;
			local_port_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_ENABLE: enable_q     <= pwdata[0];
				REG_IP:     local_ip_q   <= pwdata;
				REG_PORT:   local_port_q <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			ok_q       <= 1'b0;
			valid_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_q;
			if (m_tvalid_q && m_tready && state_q != ST_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (!enable_q) begin
							ok_q    <= 1'b0;
							state_q <= ST_RESP;
						end else if (s_tuser == CMD_CLEAR) begin
							ok_q    <= 1'b1;
							valid_q <= '0;
							count_q <= '0;
							state_q <= ST_RESP;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (idx_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (rd_vld_s1) begin
						if (cmp.match && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (cmp.free && !free_q) begin
							free_q <= 1'b1;
						end
						if (idx_s1 == LAST) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: begin
					unique case (cmd_q)
						CMD_OFFER: begin
							ok_q <= !hit_q && free_q;
							if (!hit_q && free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								count_q             <= count_q + 1'b1;
							end
						end
						CMD_STOP: begin
							ok_q <= hit_q;
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								if (count_q != '0) begin
									count_q <= count_q - 1'b1;
								end
							end
						end
						default: ok_q <= hit_q;
					endcase
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			cmd_q       <= s_tuser;
			item_q      <= s_tdata;
			res_entry_q <= '0;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (cmp.match && !hit_q) begin
				hit_idx_q   <= idx_s1;
				hit_entry_q <= rd_entry;
			end
			if (cmp.free && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_COMMIT) begin
			res_entry_q <= (cmd_q == CMD_FIND && hit_q) ? hit_entry_q : '0;
		end
		if (state_q == ST_RESP && out_free) begin
			m_tuser_q                <= ok_q;
			m_tdata_q.pad            <= 2'd0;
			m_tdata_q.entry_count    <= 6'(count_q);
			m_tdata_q.found_port     <= res_entry_q.port;
			m_tdata_q.found_ip       <= res_entry_q.ip;
			m_tdata_q.found_ttl      <= res_entry_q.ttl;
			m_tdata_q.found_minor    <= res_entry_q.minor_version;
			m_tdata_q.found_major    <= res_entry_q.major_version;
			m_tdata_q.found_instance <= res_entry_q.instance_id;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`SRT_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE,
		"accepted item did not leave idle")
	`SRT_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(ENTRIES),
		"entry count above table size")
	`SRT_ASSERT_SAME(a_count_matches_valid, clk, arst_n, 1'b1,
		$countones(valid_q) == int'(count_q), "entry count differs from valid bits")
	`SRT_ASSERT_SAME(a_read_only_in_scan, clk, arst_n, rd_vld_s1, state_q == ST_SCAN,
		"entry read outside scan")
endmodule
